/* rtl/core/ple_pkg.sv */
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants for the positional list editor
// Request and status codes, cell control struct and widths of the fields.
// ----------------------------------------------------------------------------
package ple_pkg;

   localparam int CAPACITY_DEFAULT = 64;

   localparam int DATA_W  = 32;
   localparam int POS_W   = 6;
   localparam int COUNT_W = 7;
   localparam int OP_W    = 2;
   localparam int STAT_W  = 2;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_WRITE,
      CELL_DELETE,
      CELL_ROTATE
   } cell_act_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      cell_act_type     act;
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] last_idx;
   } cell_ctl_type;

endpackage

/* rtl/core/ple_cell.sv */
// ----------------------------------------------------------------------------
// ple_cell: one list entry of the chain
// Holds a word and picks its next value from the new word, a neighbor or the head cell.
// ----------------------------------------------------------------------------
module ple_cell
   import ple_pkg::*;
(
   input  logic              clock,
   input  logic [POS_W-1:0]  cell_idx,
   input  cell_ctl_type      ctl,
   input  logic [DATA_W-1:0] new_value,
   input  logic [DATA_W-1:0] prev_data,
   input  logic [DATA_W-1:0] next_data,
   input  logic [DATA_W-1:0] head_data,
   output logic [DATA_W-1:0] data
);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctl.act)
         CELL_INSERT: begin
            if (cell_idx == ctl.pos) begin
               data_in = new_value;
            end else if (cell_idx > ctl.pos) begin
               data_in = prev_data;
            end
         end
         CELL_WRITE: begin
            if (cell_idx == ctl.pos) begin
               data_in = new_value;
            end
         end
         CELL_DELETE: begin
            if (cell_idx >= ctl.pos) begin
               data_in = next_data;
            end
         end
         CELL_ROTATE: begin
            // the entry at the end of the list wraps around to the head
            data_in = (cell_idx == ctl.last_idx) ? head_data : next_data;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

/* rtl/core/positional_list_edit.sv */
// ----------------------------------------------------------------------------
// positional_list_edit: ordered list with insert, overwrite and delete
// Edits apply to every cell of the chain in the same cycle; the list is then read out
// by rotating the chain through cell 0, one result item per cycle while the output is free.
// ----------------------------------------------------------------------------
// results: error and empty-list result items are valid in the cycle after the
//   request item; readout items follow from ST_READ while the output is free
// requests: a new request is taken only in ST_IDLE with a free output, after the
//   readout rotation through cell 0 has ended; error results keep the block idle
// reset: synchronous, clears the entry count, state, read index and output valid;
//   the cell contents are not reset
module positional_list_edit
   import ple_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // value[31:0], position[37:32], zero pad
   input  logic [OP_W-1:0]        req_tuser,  // req_type[1:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // element_value[31:0], element_index[37:32],
                                              // element_count[44:38], zero pad
   output logic [STAT_W-1:0]      rsp_tuser,  // status[1:0]
   output logic                   rsp_tlast   // last
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [IW-1:0]     rd_idx_ff, rd_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [POS_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [DATA_W-1:0] chain_data [CAPACITY];
   cell_ctl_type      ctl;

   logic [DATA_W-1:0]  req_value;
   logic [POS_W-1:0]   req_pos;
   logic [COUNT_W-1:0] pos_ext;
   logic [COUNT_W-1:0] count_ext;
   logic               out_free;
   logic               accept;
   logic               range_err;
   logic               full_err;
   logic               op_known;
   logic [CW-1:0]      count_last;

   assign req_value = req_tdata[DATA_W-1:0];
   assign req_pos   = req_tdata[DATA_W+POS_W-1:DATA_W];
   assign pos_ext   = {1'b0, req_pos};
   assign count_ext = COUNT_W'(count_ff);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign count_last = count_ff - CW'(1);

   always_comb begin
      op_known  = 1'b1;
      range_err = 1'b0;
      full_err  = 1'b0;
      case (req_tuser)
         OP_INSERT: begin
            range_err = pos_ext > count_ext;
            full_err  = count_ext == COUNT_W'(CAPACITY);
         end
         OP_WRITE, OP_DELETE: begin
            range_err = pos_ext >= count_ext;
         end
         default: begin
            op_known = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      ctl.act       = CELL_HOLD;
      ctl.pos       = req_pos;
      ctl.last_idx  = POS_W'(count_last);

      case (state_ff)
         ST_IDLE: begin
            if (accept && op_known) begin
               if (range_err || full_err) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = range_err ? ST_RANGE : ST_FULL;
                  rsp_value_in  = '0;
                  rsp_index_in  = '0;
                  rsp_count_in  = count_ext;
                  rsp_last_in   = 1'b1;
               end else begin
                  case (req_tuser)
                     OP_INSERT: begin
                        ctl.act  = CELL_INSERT;
                        count_in = count_ff + CW'(1);
                     end
                     OP_WRITE: begin
                        ctl.act = CELL_WRITE;
                     end
                     default: begin
                        ctl.act  = CELL_DELETE;
                        count_in = count_last;
                     end
                  endcase
                  rd_idx_in = '0;
                  if (count_in == '0) begin
                     // list became empty: one result with count zero
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_OK;
                     rsp_value_in  = '0;
                     rsp_index_in  = '0;
                     rsp_count_in  = '0;
                     rsp_last_in   = 1'b1;
                  end else begin
                     state_in = ST_READ;
                  end
               end
            end
         end
         ST_READ: begin
            if (out_free) begin
               ctl.act       = CELL_ROTATE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_value_in  = chain_data[0];
               rsp_index_in  = POS_W'(rd_idx_ff);
               rsp_count_in  = count_ext;
               rsp_last_in   = rd_idx_ff == IW'(count_last);
               rd_idx_in     = rd_idx_ff + IW'(1);
               if (rd_idx_ff == IW'(count_last)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] prev_d;
      logic [DATA_W-1:0] next_d;

      if (i == 0) begin : g_head
         assign prev_d = '0;
      end else begin : g_body
         assign prev_d = chain_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_d = '0;
      end else begin : g_inner
         assign next_d = chain_data[i+1];
      end

      ple_cell u_cell (
         .clock     (clock),
         .cell_idx  (POS_W'(i)),
         .ctl       (ctl),
         .new_value (req_value),
         .prev_data (prev_d),
         .next_data (next_d),
         .head_data (chain_data[0]),
         .data      (chain_data[i])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {
      {(RSP_TDATA_W - DATA_W - POS_W - COUNT_W){1'b0}},
      rsp_count_ff, rsp_index_ff, rsp_value_ff
   };
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* dv/positional_list_edit_test.sv */
// ----------------------------------------------------------------------------
// positional_list_edit_test: self-checking bench for the positional list editor
// Streams insert, overwrite and delete requests into the block, tracks the
// list in a local shadow copy and checks every readout item and error item
// field by field, with random gaps on the request side and random stalls on
// the response side.
// ----------------------------------------------------------------------------
module positional_list_edit_test;
   import ple_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_DEPTH = CAPACITY_DEFAULT;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 310;
   localparam int STALL_LIMIT = 2000;
   localparam int TAIL_CYCLES = 16;

   typedef struct {
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] word;
      logic [POS_W-1:0]  pos;
      int unsigned       gap;
      bit                drain;
   } edit_req_type;

   typedef struct {
      logic [STAT_W-1:0]  status;
      logic [DATA_W-1:0]  word;
      logic [POS_W-1:0]   index;
      logic [COUNT_W-1:0] count;
      logic               last;
   } readout_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0]        req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [STAT_W-1:0]      rsp_tuser;
   logic                   rsp_tlast;

   // request backlog and the list shadow
   edit_req_type      edit_backlog[$];
   readout_type       readout_due[$];
   logic [DATA_W-1:0] list_words[0:LIST_DEPTH-1];
   int unsigned       list_len = 0;

   // generator side bookkeeping
   int unsigned plan_len = 0;
   int unsigned counted_items = 0;
   int unsigned reqs_queued = 0;
   bit          req_quiet = 1'b0;

   int unsigned reqs_taken = 0;
   int unsigned rsp_seen = 0;
   int unsigned mismatch_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned gap_cnt = 0;
   int unsigned stall_left = 0;
   bit          rsp_quiet = 1'b0;
   logic        req_took = 1'b0;
   logic        rsp_took = 1'b0;

   positional_list_edit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic flag_mismatch(input string what);
      $display("mismatch at result %0d: %s", rsp_seen, what);
      mismatch_count++;
   endtask

   // apply one accepted edit to the shadow list and queue the items it reads out
   task automatic apply_list_edit(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] word,
                                  input logic [POS_W-1:0] pos);
      readout_type       r;
      logic [STAT_W-1:0] st;
      int                k;
      st = ST_OK;
      case (op)
         OP_INSERT: begin
            if (pos > list_len) st = ST_RANGE;
            else if (list_len >= LIST_DEPTH) st = ST_FULL;
            else begin
               for (k = list_len; k > pos; k--) list_words[k] = list_words[k-1];
               list_words[pos] = word;
               list_len++;
            end
         end
         OP_WRITE: begin
            if (pos >= list_len) st = ST_RANGE;
            else list_words[pos] = word;
         end
         OP_DELETE: begin
            if (pos >= list_len) st = ST_RANGE;
            else begin
               for (k = pos; k + 1 < list_len; k++) list_words[k] = list_words[k+1];
               list_len--;
            end
         end
         default: return;
      endcase
      if (st != ST_OK || list_len == 0) begin
         r.status = st;
         r.word   = '0;
         r.index  = '0;
         r.count  = COUNT_W'(list_len);
         r.last   = 1'b1;
         readout_due.push_back(r);
      end else begin
         for (k = 0; k < list_len; k++) begin
            r.status = ST_OK;
            r.word   = list_words[k];
            r.index  = POS_W'(k);
            r.count  = COUNT_W'(list_len);
            r.last   = (k + 1 == list_len);
            readout_due.push_back(r);
         end
      end
   endtask

   task automatic queue_req(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] word,
                            input logic [POS_W-1:0] pos, input bit drain);
      edit_req_type r;
      if ($urandom_range(0, 24) == 0) req_quiet = !req_quiet;
      r.op    = op;
      r.word  = word;
      r.pos   = pos;
      r.gap   = req_quiet ? 0 : $urandom_range(0, 13);
      r.drain = drain;
      edit_backlog.push_back(r);
      reqs_queued++;
      if (op != OP_UNUSED) counted_items++;
      // track the length only to aim positions at the valid range
      if (op == OP_INSERT && pos <= plan_len && plan_len < LIST_DEPTH) plan_len++;
      else if (op == OP_DELETE && pos < plan_len) plan_len--;
   endtask

   function automatic logic [DATA_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_cnt = 0;
      end else if (!req_tvalid || req_took) begin
         if (edit_backlog.size() == 0 || gap_cnt < edit_backlog[0].gap ||
             (edit_backlog[0].drain && readout_due.size() != 0)) begin
            gap_cnt++;
            req_tvalid <= 1'b0;
            req_tdata  <= REQ_TDATA_W'({$urandom, $urandom});
            req_tuser  <= OP_W'($urandom);
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= {2'b00, edit_backlog[0].pos, edit_backlog[0].word};
            req_tuser  <= edit_backlog[0].op;
            void'(edit_backlog.pop_front());
            gap_cnt = 0;
         end
      end
   end

   // response back-pressure, with quiet stretches of no stall
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_took) begin
            if ($urandom_range(0, 39) == 0) rsp_quiet = !rsp_quiet;
            stall_left = rsp_quiet ? 0 : $urandom_range(0, 13);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin
      readout_type e;
      if (reset) begin
         req_took <= 1'b0;
         rsp_took <= 1'b0;
         idle_cycles = 0;
      end else begin
         req_took <= req_tvalid && req_tready;
         rsp_took <= rsp_tvalid && rsp_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (readout_due.size() == 0) begin
               flag_mismatch("result item with none expected");
            end else begin
               e = readout_due.pop_front();
               if (rsp_tuser !== e.status)
                  flag_mismatch($sformatf("status %0d, expected %0d", rsp_tuser, e.status));
               if (rsp_tdata[31:0] !== e.word)
                  flag_mismatch($sformatf("element_value %h, expected %h",
                                          rsp_tdata[31:0], e.word));
               if (rsp_tdata[37:32] !== e.index)
                  flag_mismatch($sformatf("element_index %0d, expected %0d",
                                          rsp_tdata[37:32], e.index));
               if (rsp_tdata[44:38] !== e.count)
                  flag_mismatch($sformatf("element_count %0d, expected %0d",
                                          rsp_tdata[44:38], e.count));
               if (rsp_tlast !== e.last)
                  flag_mismatch($sformatf("last %b, expected %b", rsp_tlast, e.last));
            end
            rsp_seen++;
         end
         if (req_tvalid && req_tready) begin
            apply_list_edit(req_tuser, req_tdata[31:0], req_tdata[37:32]);
            reqs_taken++;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
               $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
               $display("FAILURE");
               $finish;
            end
         end
      end
   end

   initial begin
      logic [OP_W-1:0] op;
      int unsigned     roll;
      bit              growing;

      // errors on the empty list and the unused code
      queue_req(OP_DELETE, 32'h1111_1111, 6'd0, 1'b0);
      queue_req(OP_WRITE, 32'h2222_2222, 6'd0, 1'b0);
      queue_req(OP_INSERT, 32'h3333_3333, 6'd1, 1'b0);
      queue_req(OP_UNUSED, 32'hDEAD_BEEF, 6'd0, 1'b0);
      // build a short list with the extreme words, front, end and middle
      queue_req(OP_INSERT, 32'h7FFF_FFFF, 6'd0, 1'b0);
      queue_req(OP_INSERT, 32'h8000_0000, 6'd0, 1'b0);
      queue_req(OP_INSERT, 32'hFFFF_FFFF, 6'd2, 1'b0);
      queue_req(OP_INSERT, 32'h0000_0000, 6'd1, 1'b0);
      queue_req(OP_WRITE, 32'hA5A5_A5A5, 6'd3, 1'b0);
      // positions just past the end and far past it
      queue_req(OP_WRITE, 32'h5555_5555, 6'd4, 1'b0);
      queue_req(OP_DELETE, 32'h0, 6'd4, 1'b0);
      queue_req(OP_INSERT, 32'h4444_4444, 6'd63, 1'b1);
      queue_req(OP_INSERT, 32'h6666_6666, 6'd5, 1'b0);
      // delete last, first, then down to the empty list
      queue_req(OP_DELETE, 32'h0, 6'd3, 1'b0);
      queue_req(OP_DELETE, 32'h0, 6'd0, 1'b0);
      queue_req(OP_WRITE, 32'h5A5A_5A5A, 6'd1, 1'b0);
      queue_req(OP_DELETE, 32'h0, 6'd0, 1'b0);
      queue_req(OP_DELETE, 32'h0, 6'd0, 1'b0);
      queue_req(OP_DELETE, 32'h0, 6'd0, 1'b0);
      queue_req(OP_INSERT, 32'h1234_5678, 6'd0, 1'b0);
      queue_req(OP_DELETE, 32'h0, 6'd0, 1'b0);

      // fill to capacity at random positions, then hit the full list
      while (plan_len < LIST_DEPTH)
         queue_req(OP_INSERT, pick_word(), POS_W'($urandom_range(0, plan_len)), 1'b0);
      queue_req(OP_INSERT, pick_word(), 6'd63, 1'b0);
      queue_req(OP_INSERT, pick_word(), 6'd0, 1'b1);
      queue_req(OP_WRITE, pick_word(), 6'd63, 1'b0);
      queue_req(OP_DELETE, 32'h0, 6'd63, 1'b0);
      queue_req(OP_INSERT, pick_word(), 6'd63, 1'b0);

      // random part: grow and shrink phases with some noise
      growing = 1'b0;
      while (counted_items < RANDOM_ITEMS) begin
         if (plan_len == LIST_DEPTH && $urandom_range(0, 5) == 0) growing = 1'b0;
         if (plan_len == 0) growing = 1'b1;
         roll = $urandom_range(0, 99);
         if (roll < 3) op = OP_UNUSED;
         else if (growing) op = (roll < 80) ? OP_INSERT : (roll < 92) ? OP_WRITE : OP_DELETE;
         else op = (roll < 75) ? OP_DELETE : (roll < 88) ? OP_WRITE : OP_INSERT;
         if ($urandom_range(0, 9) == 0)
            queue_req(op, pick_word(), POS_W'($urandom_range(0, 63)),
                      $urandom_range(0, 29) == 0);
         else if (op == OP_INSERT)
            queue_req(op, pick_word(), POS_W'($urandom_range(0, plan_len > 63 ? 63 : plan_len)),
                      $urandom_range(0, 29) == 0);
         else
            queue_req(op, pick_word(), POS_W'(plan_len == 0 ? 0 : $urandom_range(0, plan_len - 1)),
                      $urandom_range(0, 29) == 0);
      end

      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (reqs_taken != reqs_queued || readout_due.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
